>>> sv/ucs_pkg.sv
package ucs_pkg;

    // Input word: one URL byte and its end marker.
    typedef struct packed {
        logic [7:0] url_byte;
        logic       last_byte;
    } item_t;

    // Result word: one tagged byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] segment;
        logic       run_last;
        logic       url_end;
        logic [1:0] error_code;
        logic       path_empty;
    } result_t;

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_HOST,
        PH_PORT,
        PH_PATH,
        PH_QUERY,
        PH_FRAG
    } phase_t;

    localparam logic [2:0] SEG_SCHEME     = 3'd0;
    localparam logic [2:0] SEG_SEPARATOR  = 3'd1;
    localparam logic [2:0] SEG_HOST       = 3'd2;
    localparam logic [2:0] SEG_PORT_COLON = 3'd3;
    localparam logic [2:0] SEG_PORT       = 3'd4;
    localparam logic [2:0] SEG_PATH       = 3'd5;
    localparam logic [2:0] SEG_QUERY      = 3'd6;
    localparam logic [2:0] SEG_FRAGMENT   = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_SEP    = 2'd1;
    localparam logic [1:0] ERR_PORT_CHAR = 2'd2;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result queue geometry.
    localparam int MAX_RES   = 3;
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);
    localparam int RES_NW    = $clog2(MAX_RES + 1);

endpackage

>>> sv/url_component_splitter.sv
// The results of an accepted byte are written to the result queue behind any words already there.
// A ':' or the '/' after it is held and released with the byte that decides it.
// Throughput: one byte per cycle; the result channel moves one word per cycle while result_ready
// is high, and the input takes a byte whenever the four-entry result queue holds at most one word.
// Reset (rst_n low, asynchronous) returns to the scheme phase, empties the queue and
// clears fragment_in_path.
module url_component_splitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  ucs_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output ucs_pkg::result_t  result
);
    import ucs_pkg::*;

    logic                fip_reg;
    phase_t              phase_reg, phase_next;
    logic [1:0]          held_reg, held_next;
    logic                path_seen_reg, path_seen_next;
    logic                swallow_reg, swallow_next;

    result_t             mem_reg [RES_DEPTH];
    logic [RES_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_CW-1:0]   count_reg, count_next;

    result_t             res [MAX_RES];
    logic [RES_NW-1:0]   n;
    logic [1:0]          err;
    logic                accept, pop;
    logic [7:0]          b;
    logic                last;

    assign cfg_ready    = 1'b1;
    assign item_ready   = count_reg <= RES_CW'(RES_DEPTH - MAX_RES);
    assign accept       = item_valid && item_ready;
    assign result_valid = count_reg != '0;
    assign pop          = result_valid && result_ready;
    assign result       = mem_reg[rd_ptr_reg];
    assign b            = item.url_byte;
    assign last         = item.last_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        path_seen_next = path_seen_reg;
        swallow_next   = swallow_reg;
        err            = ERR_NONE;
        n              = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end

        if (swallow_reg)
        begin
            if (last)
            begin
                res[n].out_byte = b; res[n].segment = SEG_PORT;
                res[n].error_code = ERR_PORT_CHAR; n = n + 1'b1;
                err = ERR_PORT_CHAR;
            end
        end
        else
        begin
            case (phase_reg)
                PH_SCHEME:
                begin
                    case (held_reg)
                        2'd0:
                        begin
                            if (b == CH_COLON && !last)
                            begin
                                held_next = 2'd1;
                            end
                            else
                            begin
                                res[n].out_byte = b; res[n].segment = SEG_SCHEME; n = n + 1'b1;
                            end
                        end
                        2'd1:
                        begin
                            if (b == CH_SLASH && !last)
                            begin
                                held_next = 2'd2;
                            end
                            else
                            begin
                                res[n].out_byte = CH_COLON; res[n].segment = SEG_SCHEME;
                                n = n + 1'b1;
                                res[n].out_byte = b; res[n].segment = SEG_SCHEME; n = n + 1'b1;
                                held_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            held_next = 2'd0;
                            if (b == CH_SLASH)
                            begin
                                res[n].out_byte = CH_COLON; res[n].segment = SEG_SEPARATOR;
                                n = n + 1'b1;
                                res[n].out_byte = CH_SLASH; res[n].segment = SEG_SEPARATOR;
                                n = n + 1'b1;
                                res[n].out_byte = b; res[n].segment = SEG_SEPARATOR;
                                n = n + 1'b1;
                                phase_next = PH_HOST;
                            end
                            else
                            begin
                                res[n].out_byte = CH_COLON; res[n].segment = SEG_SCHEME;
                                n = n + 1'b1;
                                res[n].out_byte = CH_SLASH; res[n].segment = SEG_SCHEME;
                                n = n + 1'b1;
                                if (b == CH_COLON && !last)
                                begin
                                    held_next = 2'd1;
                                end
                                else
                                begin
                                    res[n].out_byte = b; res[n].segment = SEG_SCHEME;
                                    n = n + 1'b1;
                                end
                            end
                        end
                    endcase
                    if (last && phase_next == PH_SCHEME)
                    begin
                        err = ERR_NO_SEP;
                    end
                end
                PH_HOST, PH_PORT, PH_PATH:
                begin
                    if (phase_reg == PH_HOST && b == CH_COLON)
                    begin
                        phase_next = PH_PORT;
                        res[n].out_byte = b; res[n].segment = SEG_PORT_COLON; n = n + 1'b1;
                    end
                    else if (phase_reg == PH_PATH || b == CH_SLASH || b == CH_HASH)
                    begin
                        // Byte handled as a path byte: '?' and an unmasked '#' leave the path.
                        res[n].out_byte = b;
                        if (b == CH_QMARK)
                        begin
                            phase_next = PH_QUERY;
                            res[n].segment = SEG_QUERY;
                        end
                        else if (b == CH_HASH && !fip_reg)
                        begin
                            phase_next = PH_FRAG;
                            res[n].segment = SEG_FRAGMENT;
                        end
                        else
                        begin
                            phase_next = PH_PATH;
                            path_seen_next = 1'b1;
                            res[n].segment = SEG_PATH;
                        end
                        n = n + 1'b1;
                    end
                    else if (phase_reg == PH_HOST)
                    begin
                        res[n].out_byte = b; res[n].segment = SEG_HOST; n = n + 1'b1;
                    end
                    else if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        res[n].out_byte = b; res[n].segment = SEG_PORT; n = n + 1'b1;
                    end
                    else
                    begin
                        res[n].out_byte = b; res[n].segment = SEG_PORT;
                        res[n].error_code = ERR_PORT_CHAR; n = n + 1'b1;
                        swallow_next = 1'b1;
                        err = ERR_PORT_CHAR;
                    end
                end
                PH_QUERY:
                begin
                    res[n].out_byte = b;
                    if (b == CH_HASH)
                    begin
                        phase_next = PH_FRAG;
                        res[n].segment = SEG_FRAGMENT;
                    end
                    else
                    begin
                        res[n].segment = SEG_QUERY;
                    end
                    n = n + 1'b1;
                end
                default:
                begin
                    res[n].out_byte = b; res[n].segment = SEG_FRAGMENT; n = n + 1'b1;
                end
            endcase
        end

        // Mark the closing word of this byte and, on the final byte, of the URL.
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (RES_NW'(i + 1) == n)
            begin
                res[i].run_last = 1'b1;
                if (last)
                begin
                    res[i].url_end    = 1'b1;
                    res[i].error_code = err;
                    res[i].path_empty = (err == ERR_NONE) && !path_seen_next;
                end
            end
        end

        if (last)
        begin
            phase_next     = PH_SCHEME;
            held_next      = 2'd0;
            path_seen_next = 1'b0;
            swallow_next   = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + RES_CW'(n);
        end
        if (pop)
        begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fip_reg       <= 1'b0;
            phase_reg     <= PH_SCHEME;
            held_reg      <= 2'd0;
            path_seen_reg <= 1'b0;
            swallow_reg   <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fip_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                held_reg      <= held_next;
                path_seen_reg <= path_seen_next;
                swallow_reg   <= swallow_next;
                wr_ptr_reg    <= wr_ptr_reg + RES_AW'(n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (accept && RES_NW'(i) < n)
            begin
                mem_reg[wr_ptr_reg + RES_AW'(i)] <= res[i];
            end
        end
    end

endmodule

>>> sv/ucs_checker.sv
module ucs_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input ucs_pkg::result_t  result
);
    import ucs_pkg::*;

    // A stalled word stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.url_end |-> result.run_last)
        else $error("url_end without run_last");

    a_path_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.path_empty |-> result.url_end && result.error_code == ERR_NONE)
        else $error("path_empty outside a clean URL end");

    a_no_sep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code == ERR_NO_SEP
        |-> result.url_end && result.segment == SEG_SCHEME)
        else $error("missing separator error on a non-final or non-scheme word");

    a_port_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code == ERR_PORT_CHAR |-> result.segment == SEG_PORT)
        else $error("port error on a non-port word");

endmodule

bind url_component_splitter ucs_port_checker u_ucs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
